// ----- src/prat_pkg.sv -----
`default_nettype none

package prat_pkg;

    // Item commands.
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_INIT   = 2'd1;
    localparam logic [1:0] CMD_TUNE   = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] CFG_GAIN_P  = 3'd0;
    localparam logic [2:0] CFG_GAIN_I  = 3'd1;
    localparam logic [2:0] CFG_GAIN_D  = 3'd2;
    localparam logic [2:0] CFG_REVERSE = 3'd3;
    localparam logic [2:0] CFG_BAND    = 3'd4;
    localparam logic [2:0] CFG_UPPER   = 3'd5;
    localparam logic [2:0] CFG_LOWER   = 3'd6;

    // Relay autotune phases.
    localparam logic [2:0] PH_WAIT_BELOW1 = 3'd0;
    localparam logic [2:0] PH_WAIT_ABOVE1 = 3'd1;
    localparam logic [2:0] PH_WAIT_BELOW2 = 3'd2;
    localparam logic [2:0] PH_TRACK_MIN   = 3'd3;
    localparam logic [2:0] PH_TRACK_MAX   = 3'd4;
    localparam logic [2:0] PH_WAIT_END    = 3'd5;

    localparam logic [9:0]  GAIN_MAX  = 10'd999;
    localparam logic [9:0]  GAIN_MIN  = 10'd1;
    localparam logic [9:0]  DRIVE_MAX = 10'd1000;
    localparam logic [15:0] TICK_STEP = 16'd5;
    // 2400/pi in Q8, and twenty times that for the integral gain.
    localparam logic [17:0] K_Q8      = 18'd195570;
    localparam logic [21:0] KI_NUM    = 22'd3911400;
    localparam logic [6:0]  KD_SCALE  = 7'd80;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ERR,
        S_INTEG,
        S_MUL_P,
        S_MUL_I,
        S_MUL_D,
        S_SUM_D,
        S_CLAMP,
        S_TUNE,
        S_FIN,
        S_T_MA,
        S_T_MB,
        S_T_MC,
        S_T_MD,
        S_DP_WAIT,
        S_DI_GO,
        S_DI_WAIT,
        S_DD_GO,
        S_DD_WAIT,
        S_FIN_END,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

// ----- src/pid_position_with_relay_autotune.sv -----
`default_nettype none

// Positional PID controller with relay autotune. Each item carries a command, a
// setpoint and a measurement and returns one result: the drive (0..1000), the tuning
// flags and the gains in use. All arithmetic runs through one shared multiplier and an
// accumulator under a small sequencer, and the block takes no item until the result
// has been taken. A control sample steps through error, integral, the P, I and D
// products, sum and clamp; init, ignored and ordinary tuning items skip that work. The
// item that ends autotune works the gains out, where amplitude and period allow, with
// a shared restoring divider that produces one quotient bit per cycle. Configuration
// writes are accepted at any time but must only be issued while the block is idle.
module pid_position_with_relay_autotune
    import prat_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               sample_valid,
    output logic                    sample_stall,
    input  wire logic [1:0]         cmd,
    input  wire logic signed [15:0] setpoint,
    input  wire logic signed [15:0] measured,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [9:0]              drive,
    output logic                    tuning,
    output logic                    tune_done,
    output logic [9:0]              cur_kp,
    output logic [9:0]              cur_ki,
    output logic [9:0]              cur_kd,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [11:0]        cfg_data
);

    state_t state_reg, state_next;

    // Configuration.
    logic [9:0]         gp_init_reg, gi_init_reg, gd_init_reg;
    logic               reverse_reg;
    logic [9:0]         band_reg;
    logic signed [11:0] upper_reg, lower_reg;

    // Loop state.
    logic [9:0]         gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [17:0] prev_err_reg;
    logic signed [11:0] integ_reg;
    logic [9:0]         drive_reg;
    logic               tune_active_reg;
    logic               done_reg;
    logic [2:0]         phase_reg;
    logic [15:0]        tick_reg, ct_low_reg, ct_high_reg;
    logic signed [15:0] min_reg, max_reg;
    logic               min_valid_reg, max_valid_reg;

    // Per-item working registers.
    logic [1:0]         cmd_reg;
    logic signed [15:0] sp_reg, ms_reg;
    logic signed [17:0] err_reg;
    logic signed [38:0] prod_reg;
    logic signed [29:0] sum_reg;
    logic [15:0]        am_reg, dm_reg;
    logic               neg_a_reg, neg_d_reg, d_zero_reg;
    logic [39:0]        den_i_reg;
    logic [33:0]        num_d_reg;
    logic [30:0]        den_d_reg;

    // Shared multiplier.
    logic signed [19:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [38:0] mul_p;

    logic               div_start;
    logic [33:0]        div_num;
    logic [39:0]        div_den;
    logic               div_done;
    logic [9:0]         div_q;

    logic signed [16:0] diff17;
    logic signed [17:0] err_new;
    logic [17:0]        err_mag;
    logic signed [12:0] acc13;
    logic signed [12:0] acc_up;
    logic signed [11:0] acc_final;
    logic               below;
    logic [15:0]        tick_inc;
    logic signed [16:0] amp, per;
    logic               neg_any;

    assign diff17  = 17'(sp_reg) - 17'(ms_reg);
    assign err_new = reverse_reg ? -18'(diff17) : 18'(diff17);
    assign err_mag = err_reg[17] ? 18'(-err_reg) : 18'(err_reg);

    always_comb
    begin
        if (err_mag <= {8'b0, band_reg})
        begin
            acc13 = 13'(integ_reg) + 13'($signed(err_reg[11:0]));
        end
        else
        begin
            acc13 = 13'sd0;
        end
        acc_up = (acc13 > 13'(upper_reg)) ? 13'(upper_reg) : acc13;
        acc_final = (acc_up < 13'(lower_reg)) ? lower_reg : acc_up[11:0];
    end

    assign below    = ms_reg < sp_reg;
    assign tick_inc = tick_reg + TICK_STEP;
    assign amp      = (max_valid_reg ? 17'(max_reg) : 17'sd0)
                    - (min_valid_reg ? 17'(min_reg) : 17'sd0);
    assign per      = $signed({1'b0, ct_high_reg}) - $signed({1'b0, ct_low_reg});
    assign neg_any  = neg_a_reg ^ neg_d_reg;

    always_comb
    begin
        mul_a = 20'sd0;
        mul_b = 19'sd0;
        case (state_reg)
            S_MUL_P:
            begin
                mul_a = $signed({10'b0, gain_p_reg});
                mul_b = 19'(err_reg);
            end
            S_MUL_I:
            begin
                mul_a = $signed({10'b0, gain_i_reg});
                mul_b = 19'(integ_reg);
            end
            S_MUL_D:
            begin
                mul_a = $signed({10'b0, gain_d_reg});
                mul_b = 19'(err_reg) - 19'(prev_err_reg);
            end
            S_T_MA:
            begin
                mul_a = $signed({4'b0, am_reg});
                mul_b = $signed({3'b0, dm_reg});
            end
            S_T_MB:
            begin
                mul_a = $signed({2'b0, K_Q8});
                mul_b = $signed({3'b0, dm_reg});
            end
            S_T_MC:
            begin
                mul_a = $signed({4'b0, am_reg});
                mul_b = $signed({12'b0, KD_SCALE});
            end
            default:
            begin
                mul_a = 20'sd0;
                mul_b = 19'sd0;
            end
        endcase
    end

    assign mul_p = 39'(mul_a) * 39'(mul_b);

    always_comb
    begin
        div_num = {16'b0, K_Q8};
        div_den = {16'b0, am_reg, 8'b0};
        case (state_reg)
            S_DI_GO:
            begin
                div_num = {12'b0, KI_NUM};
                div_den = den_i_reg;
            end
            S_DD_GO:
            begin
                div_num = num_d_reg;
                div_den = {9'b0, den_d_reg};
            end
            default:
            begin
                div_num = {16'b0, K_Q8};
                div_den = {16'b0, am_reg, 8'b0};
            end
        endcase
    end

    prat_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .q     (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                if (cmd_reg == CMD_SAMPLE || cmd_reg == CMD_TUNE)
                begin
                    if (tune_active_reg || cmd_reg == CMD_TUNE)
                    begin
                        state_next = S_TUNE;
                    end
                    else
                    begin
                        state_next = S_INTEG;
                    end
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_INTEG:   state_next = S_MUL_P;
            S_MUL_P:   state_next = S_MUL_I;
            S_MUL_I:   state_next = S_MUL_D;
            S_MUL_D:   state_next = S_SUM_D;
            S_SUM_D:   state_next = S_CLAMP;
            S_CLAMP:   state_next = S_OUT;
            S_TUNE:
            begin
                if (phase_reg == PH_WAIT_END && !below)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_FIN:
            begin
                state_next = (amp == 17'sd0) ? S_FIN_END : S_T_MA;
            end
            S_T_MA:    state_next = S_T_MB;
            S_T_MB:    state_next = S_T_MC;
            S_T_MC:    state_next = S_T_MD;
            S_T_MD:
            begin
                div_start  = 1'b1;
                state_next = S_DP_WAIT;
            end
            S_DP_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_DI_GO;
                end
            end
            S_DI_GO:
            begin
                if (d_zero_reg)
                begin
                    state_next = S_DD_GO;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DI_WAIT;
                end
            end
            S_DI_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_DD_GO;
                end
            end
            S_DD_GO:
            begin
                if (d_zero_reg)
                begin
                    state_next = S_FIN_END;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DD_WAIT;
                end
            end
            S_DD_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_FIN_END;
                end
            end
            S_FIN_END: state_next = S_OUT;
            S_OUT:
            begin
                if (!result_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Working registers; they have no reset.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        if (state_reg == S_IDLE && sample_valid)
        begin
            cmd_reg <= cmd;
            sp_reg  <= setpoint;
            ms_reg  <= measured;
        end
        case (state_reg)
            S_ERR:   err_reg <= err_new;
            S_INTEG: sum_reg <= 30'sd0;
            S_MUL_I, S_MUL_D, S_SUM_D: sum_reg <= sum_reg + prod_reg[29:0];
            S_FIN:
            begin
                am_reg     <= amp[16] ? 16'(-amp) : amp[15:0];
                dm_reg     <= per[16] ? 16'(-per) : per[15:0];
                neg_a_reg  <= amp[16];
                neg_d_reg  <= per[16];
                d_zero_reg <= (per == 17'sd0);
            end
            S_T_MB:  den_i_reg <= {prod_reg[31:0], 8'b0};
            S_T_MC:  num_d_reg <= prod_reg[33:0];
            S_T_MD:  den_d_reg <= {prod_reg[22:0], 8'b0};
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gp_init_reg     <= 10'd1;
            gi_init_reg     <= 10'd1;
            gd_init_reg     <= 10'd1;
            reverse_reg     <= 1'b0;
            band_reg        <= 10'd10;
            upper_reg       <= 12'sd1000;
            lower_reg       <= -12'sd100;
            gain_p_reg      <= 10'd0;
            gain_i_reg      <= 10'd0;
            gain_d_reg      <= 10'd0;
            prev_err_reg    <= 18'sd0;
            integ_reg       <= 12'sd0;
            drive_reg       <= 10'd0;
            tune_active_reg <= 1'b0;
            done_reg        <= 1'b0;
            phase_reg       <= PH_WAIT_BELOW1;
            tick_reg        <= 16'd0;
            ct_low_reg      <= 16'd0;
            ct_high_reg     <= 16'd0;
            min_reg         <= 16'sd0;
            max_reg         <= 16'sd0;
            min_valid_reg   <= 1'b0;
            max_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_GAIN_P:  gp_init_reg <= cfg_data[9:0];
                    CFG_GAIN_I:  gi_init_reg <= cfg_data[9:0];
                    CFG_GAIN_D:  gd_init_reg <= cfg_data[9:0];
                    CFG_REVERSE: reverse_reg <= cfg_data[0];
                    CFG_BAND:    band_reg    <= cfg_data[9:0];
                    CFG_UPPER:   upper_reg   <= $signed(cfg_data);
                    CFG_LOWER:   lower_reg   <= $signed(cfg_data);
                    default:     reverse_reg <= reverse_reg;
                endcase
            end

            case (state_reg)
                S_ERR:
                begin
                    done_reg <= 1'b0;
                    if (cmd_reg == CMD_INIT)
                    begin
                        gain_p_reg   <= gp_init_reg;
                        gain_i_reg   <= gi_init_reg;
                        gain_d_reg   <= gd_init_reg;
                        prev_err_reg <= 18'sd0;
                        integ_reg    <= 12'sd0;
                        drive_reg    <= 10'd0;
                    end
                    else if (cmd_reg == CMD_TUNE)
                    begin
                        tune_active_reg <= 1'b1;
                    end
                end
                S_INTEG: integ_reg <= acc_final;
                S_MUL_D: prev_err_reg <= err_reg;
                S_CLAMP:
                begin
                    if (sum_reg < 30'sd0)
                    begin
                        drive_reg <= 10'd0;
                    end
                    else if (sum_reg > 30'(DRIVE_MAX))
                    begin
                        drive_reg <= DRIVE_MAX;
                    end
                    else
                    begin
                        drive_reg <= sum_reg[9:0];
                    end
                end
                S_TUNE:
                begin
                    tick_reg  <= tick_inc;
                    drive_reg <= (err_reg > 18'sd0) ? DRIVE_MAX : 10'd0;
                    case (phase_reg)
                        PH_WAIT_BELOW1:
                        begin
                            if (below)
                            begin
                                phase_reg <= PH_WAIT_ABOVE1;
                            end
                        end
                        PH_WAIT_ABOVE1:
                        begin
                            if (!below)
                            begin
                                phase_reg <= PH_WAIT_BELOW2;
                            end
                        end
                        PH_WAIT_BELOW2:
                        begin
                            if (below)
                            begin
                                phase_reg <= PH_TRACK_MIN;
                            end
                        end
                        PH_TRACK_MIN:
                        begin
                            if (!below)
                            begin
                                phase_reg  <= PH_TRACK_MAX;
                                ct_low_reg <= tick_inc;
                            end
                            if (!min_valid_reg || ms_reg < min_reg)
                            begin
                                min_reg       <= ms_reg;
                                min_valid_reg <= 1'b1;
                            end
                        end
                        PH_TRACK_MAX:
                        begin
                            if (below)
                            begin
                                phase_reg   <= PH_WAIT_END;
                                ct_high_reg <= tick_inc;
                            end
                            if (!max_valid_reg || ms_reg > max_reg)
                            begin
                                max_reg       <= ms_reg;
                                max_valid_reg <= 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_reg <= phase_reg;
                        end
                    endcase
                end
                S_FIN:
                begin
                    // Zero amplitude saturates all three gains.
                    if (amp == 17'sd0)
                    begin
                        gain_p_reg <= GAIN_MAX;
                        gain_i_reg <= GAIN_MAX;
                        gain_d_reg <= GAIN_MAX;
                    end
                end
                S_DP_WAIT:
                begin
                    if (div_done)
                    begin
                        gain_p_reg <= neg_a_reg ? GAIN_MIN : div_q;
                    end
                end
                S_DI_GO:
                begin
                    if (d_zero_reg)
                    begin
                        gain_i_reg <= neg_a_reg ? GAIN_MIN : GAIN_MAX;
                    end
                end
                S_DI_WAIT:
                begin
                    if (div_done)
                    begin
                        gain_i_reg <= neg_any ? GAIN_MIN : div_q;
                    end
                end
                S_DD_GO:
                begin
                    if (d_zero_reg)
                    begin
                        gain_d_reg <= GAIN_MIN;
                    end
                end
                S_DD_WAIT:
                begin
                    if (div_done)
                    begin
                        gain_d_reg <= neg_any ? GAIN_MIN : div_q;
                    end
                end
                S_FIN_END:
                begin
                    gp_init_reg     <= gain_p_reg;
                    gi_init_reg     <= gain_i_reg;
                    gd_init_reg     <= gain_d_reg;
                    done_reg        <= 1'b1;
                    tune_active_reg <= 1'b0;
                    phase_reg       <= PH_WAIT_BELOW1;
                    tick_reg        <= 16'd0;
                    ct_low_reg      <= 16'd0;
                    ct_high_reg     <= 16'd0;
                    min_reg         <= 16'sd0;
                    max_reg         <= 16'sd0;
                    min_valid_reg   <= 1'b0;
                    max_valid_reg   <= 1'b0;
                end
                default:
                begin
                    done_reg <= done_reg;
                end
            endcase
        end
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_OUT);
    assign cfg_ready    = 1'b1;
    assign drive        = drive_reg;
    assign tuning       = tune_active_reg;
    assign tune_done    = done_reg;
    assign cur_kp       = gain_p_reg;
    assign cur_ki       = gain_i_reg;
    assign cur_kd       = gain_d_reg;

    a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> sample_stall)
        else $error("item accepted while a result is pending");

    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> drive <= DRIVE_MAX)
        else $error("drive above its clamp");

    a_done_ends_tune: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && tune_done) |-> (!tuning && cur_kp != 10'd0 && cur_kd != 10'd0))
        else $error("autotune finished without tuned gains");

    a_div_only_when_tuning: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> tune_active_reg)
        else $error("divider started outside autotune");

endmodule

`default_nettype wire

// ----- src/prat_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle, result clamped to 1..999.
module prat_div
    import prat_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [33:0] num,
    input  wire logic [39:0] den,
    output logic             done,
    output logic [9:0]       q
);

    logic [33:0] rem_reg;
    logic [49:0] dsh_reg;
    logic [10:0] qb_reg;
    logic [3:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic        ge;

    assign ge = {16'b0, rem_reg} >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 4'd10;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= {den, 10'b0};
            qb_reg  <= 11'd0;
        end
        else if (run_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg[33:0];
            end
            qb_reg  <= {qb_reg[9:0], ge};
            dsh_reg <= {1'b0, dsh_reg[49:1]};
        end
    end

    // A set top bit means the quotient is 1024 or more.
    always_comb
    begin
        if (qb_reg[10] || qb_reg[9:0] >= GAIN_MAX)
        begin
            q = GAIN_MAX;
        end
        else if (qb_reg[9:0] <= GAIN_MIN)
        begin
            q = GAIN_MIN;
        end
        else
        begin
            q = qb_reg[9:0];
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire
